@@ rtl/lmbp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package lmbp_pkg;

    // Fixed field widths
    localparam int PIXEL_W = 12;
    localparam int PIN_W   = 10;

    // Item operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_SCAN  = 1'b1;

    // Control word for the encoder stage, aligned with the RAM read data
    typedef struct packed {
        logic       valid;
        logic       last;
        logic       clear_prev;
        logic [1:0] plane;
        logic [3:0] row;
    } enc_ctrl_t;

endpackage
`default_nettype wire

@@ rtl/led_matrix_bitplane_pin_encoder_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// LED matrix bit-plane pin encoder.
// Command channel: an item is taken at a clock edge with start high and busy
// low. operation selects a pixel write or a row bit-plane scan.
// A pixel write lands in the frame buffer in the accepting cycle; busy stays
// low, so another item can follow in the next cycle. Out-of-range writes and
// scans are dropped with no result.
// A scan streams PANEL_COLUMNS words, one per cycle, the first word passing
// the column register, the RAM read register and the encoder output register
// on its way to the result ports. result_valid marks each word for exactly
// one cycle; the receiver cannot stall the stream. busy stays high until the
// last read is in the output stage. The two frame buffer halves (one RAM
// each) are read in parallel, one column per cycle.
// Each word gives the pins rising and falling against the previous word;
// restart_delta zeroes that previous word first.
// Reset: the previous word clears at once, then a clearing pass zeroes the
// frame buffer at all SCAN_ROWS * PANEL_COLUMNS addresses (1024 at the
// defaults), with busy high throughout.
module led_matrix_bitplane_pin_encoder_unit #(
    parameter int SCAN_ROWS     = 16,
    parameter int PANEL_COLUMNS = 64,
    parameter int PLANE_COUNT   = 4
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            operation,
    input  logic [4:0]                      pixel_row,
    input  logic [5:0]                      pixel_column,
    input  logic [lmbp_pkg::PIXEL_W-1:0]    pixel_value,
    input  logic [3:0]                      scan_row,
    input  logic [1:0]                      bit_plane,
    input  logic                            restart_delta,
    output logic                            result_valid,
    output logic [lmbp_pkg::PIN_W-1:0]      set_mask,
    output logic [lmbp_pkg::PIN_W-1:0]      reset_mask,
    output logic [5:0]                      column_index,
    output logic                            last_word
);
    import lmbp_pkg::*;

    localparam int DEPTH = SCAN_ROWS * PANEL_COLUMNS;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(PANEL_COLUMNS);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;

    logic [1:0]    state_reg, state_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic [CW-1:0] col_reg, col_next;
    logic [3:0]    row_reg, row_next;
    logic [1:0]    plane_reg, plane_next;
    logic          s1_valid_reg, s1_valid_next;
    logic          s1_last_reg, s1_last_next;
    logic [CW-1:0] s1_col_reg, s1_col_next;

    logic          accept;
    logic          scan_ok, write_ok, wr_upper, col_last;
    logic [AW-1:0] wr_addr, rd_addr, ram_waddr;
    logic [PIXEL_W-1:0] ram_wdata, upper_px, lower_px;
    logic          we_upper, we_lower;
    enc_ctrl_t     ctrl;

    assign busy   = (state_reg != ST_IDLE) || s1_valid_reg;
    assign accept = start && !busy;

    // Item decode
    assign scan_ok  = (int'(scan_row) < SCAN_ROWS) && (int'(bit_plane) < PLANE_COUNT);
    assign write_ok = (int'(pixel_row) < 2 * SCAN_ROWS)
                   && (int'(pixel_column) < PANEL_COLUMNS);
    assign wr_upper = int'(pixel_row) < SCAN_ROWS;
    assign wr_addr  = wr_upper
        ? AW'(int'(pixel_row) * PANEL_COLUMNS + int'(pixel_column))
        : AW'((int'(pixel_row) - SCAN_ROWS) * PANEL_COLUMNS + int'(pixel_column));
    assign rd_addr  = AW'(int'(row_reg) * PANEL_COLUMNS + int'(col_reg));
    assign col_last = col_reg == CW'(PANEL_COLUMNS - 1);

    // Frame buffer write port: clearing pass or pixel write
    always_comb
    begin
        ram_waddr = wr_addr;
        ram_wdata = pixel_value;
        we_upper  = 1'b0;
        we_lower  = 1'b0;
        if (state_reg == ST_CLEAR)
        begin
            ram_waddr = clr_cnt_reg;
            ram_wdata = '0;
            we_upper  = 1'b1;
            we_lower  = 1'b1;
        end
        else if (accept && operation == OP_WRITE && write_ok)
        begin
            we_upper = wr_upper;
            we_lower = !wr_upper;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next    = state_reg;
        clr_cnt_next  = clr_cnt_reg;
        col_next      = col_reg;
        row_next      = row_reg;
        plane_next    = plane_reg;
        s1_valid_next = 1'b0;
        s1_last_next  = s1_last_reg;
        s1_col_next   = s1_col_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && operation == OP_SCAN && scan_ok)
                begin
                    state_next = ST_SCAN;
                    col_next   = '0;
                    row_next   = scan_row;
                    plane_next = bit_plane;
                end
            end
            ST_SCAN:
            begin
                s1_valid_next = 1'b1;
                s1_last_next  = col_last;
                s1_col_next   = col_reg;
                col_next      = col_reg + CW'(1);
                if (col_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_cnt_reg  <= clr_cnt_next;
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        col_reg     <= col_next;
        row_reg     <= row_next;
        plane_reg   <= plane_next;
        s1_last_reg <= s1_last_next;
        s1_col_reg  <= s1_col_next;
    end

    // Frame buffer halves: upper rows and lower rows
    lmbp_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_ram_upper (
        .clk   (clk),
        .we    (we_upper),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (upper_px)
    );

    lmbp_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_ram_lower (
        .clk   (clk),
        .we    (we_lower),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_addr),
        .rdata (lower_px)
    );

    // Encoder stage control, aligned with read data
    assign ctrl.valid      = s1_valid_reg;
    assign ctrl.last       = s1_last_reg;
    assign ctrl.clear_prev = accept && operation == OP_SCAN && scan_ok && restart_delta;
    assign ctrl.plane      = plane_reg;
    assign ctrl.row        = row_reg;

    lmbp_encoder #(
        .CW (CW)
    ) u_encoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl         (ctrl),
        .col          (s1_col_reg),
        .upper        (upper_px),
        .lower        (lower_px),
        .result_valid (result_valid),
        .set_mask     (set_mask),
        .reset_mask   (reset_mask),
        .column_index (column_index),
        .last_word    (last_word)
    );

endmodule
`default_nettype wire

@@ rtl/lmbp_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lmbp_ram #(
    parameter int WIDTH = 12,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

@@ rtl/lmbp_encoder.sv @@
`timescale 1ns / 1ps
`default_nettype none
module lmbp_encoder #(
    parameter int CW = 6
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  lmbp_pkg::enc_ctrl_t             ctrl,
    input  logic [CW-1:0]                   col,
    input  logic [lmbp_pkg::PIXEL_W-1:0]    upper,
    input  logic [lmbp_pkg::PIXEL_W-1:0]    lower,
    output logic                            result_valid,
    output logic [lmbp_pkg::PIN_W-1:0]      set_mask,
    output logic [lmbp_pkg::PIN_W-1:0]      reset_mask,
    output logic [5:0]                      column_index,
    output logic                            last_word
);
    import lmbp_pkg::*;

    logic [PIN_W-1:0] prev_reg, prev_next;
    logic [PIN_W-1:0] pin_word;
    logic [PIN_W-1:0] diff;
    logic [CW+5:0]    col_ext;
    logic [3:0]       pos_b, pos_g, pos_r;

    logic             valid_reg;
    logic [PIN_W-1:0] set_reg, clr_reg;
    logic [5:0]       col_reg;
    logic             last_reg;

    // Bit positions of the plane within each color channel
    assign pos_b = {2'b00, ctrl.plane};
    assign pos_g = pos_b + 4'd4;
    assign pos_r = pos_b + 4'd8;

    // Pin word: R1 G1 B1 R2 G2 B2, then row address A-D
    assign pin_word = {ctrl.row,
                       lower[pos_b], lower[pos_g], lower[pos_r],
                       upper[pos_b], upper[pos_g], upper[pos_r]};

    assign diff    = prev_reg ^ pin_word;
    assign col_ext = {6'b000000, col};

    // Previous word: cleared on restart, follows each emitted word
    always_comb
    begin
        prev_next = prev_reg;
        if (ctrl.clear_prev)
        begin
            prev_next = '0;
        end
        else if (ctrl.valid)
        begin
            prev_next = pin_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg  <= prev_next;
            valid_reg <= ctrl.valid;
        end
    end

    // Output word registers
    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            set_reg  <= diff & pin_word;
            clr_reg  <= diff & prev_reg;
            col_reg  <= col_ext[5:0];
            last_reg <= ctrl.last;
        end
    end

    assign result_valid = valid_reg;
    assign set_mask     = set_reg;
    assign reset_mask   = clr_reg;
    assign column_index = col_reg;
    assign last_word    = last_reg;

endmodule
`default_nettype wire
